### sv/lbb_pkg.sv
package lbb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RADIUS_W   = 5;
  localparam int MAX_RADIUS = 31;
  localparam int MAX_LINE   = 4096;

  // one cell per tap of the widest window
  localparam int NUM_CELLS  = 2 * MAX_RADIUS + 1;
  localparam int CELL_IDX_W = $clog2(NUM_CELLS);
  // window length 2r+1
  localparam int WIN_W      = $clog2(2 * MAX_RADIUS + 2);
  // signed window sum and its magnitude
  localparam int SUM_W      = SAMPLE_W + WIN_W;
  localparam int MAG_W      = SUM_W - 1;
  localparam int DIV_CNT_W  = $clog2(MAG_W);
  localparam int POS_W      = $clog2(MAX_LINE);
  localparam int CMP_W      = (POS_W > RADIUS_W) ? POS_W : RADIUS_W;

  typedef struct packed {
    logic fill;   // load every cell from the bus
    logic shift;  // advance the chain by one word
  } cell_ctrl_t;

endpackage

### sv/lbb_intf.sv
interface lbb_in_if import lbb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_line;

  modport source (output valid, sample, last_in_line, input ready);
  modport sink   (input valid, sample, last_in_line, output ready);
endinterface

interface lbb_out_if import lbb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;
  logic                       line_end;

  modport source (output valid, average, line_end, input ready);
  modport sink   (input valid, average, line_end, output ready);
endinterface

interface lbb_cfg_if import lbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] radius;

  modport source (output valid, radius, input ready);
  modport sink   (input valid, radius, output ready);
endinterface

### sv/lbb_cell.sv
module lbb_cell import lbb_pkg::*; (
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  input  logic                       entry_i,
  input  logic signed [SAMPLE_W-1:0] bus_i,
  input  logic signed [SAMPLE_W-1:0] prev_i,
  output logic signed [SAMPLE_W-1:0] val_o
);

  logic signed [SAMPLE_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.fill || (ctrl_i.shift && entry_i)) begin
      val_d = bus_i;
    end else if (ctrl_i.shift) begin
      val_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

### sv/lbb_div.sv
module lbb_div import lbb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_W-1:0]    dividend_i,
  input  logic        [WIN_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     mag_q, mag_d;
  logic [WIN_W-1:0]     rem_q, rem_d;
  logic [WIN_W-1:0]     div_q, div_d;
  logic                 neg_q, neg_d;

  logic [WIN_W:0]   rem_sh;
  logic             ge;
  logic [SUM_W-1:0] abs_in;
  logic [MAG_W-1:0] q_signed;

  assign abs_in = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign rem_sh = {rem_q, mag_q[MAG_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  // one quotient bit per cycle, remainder tracked on the side
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mag_d  = abs_in[MAG_W-1:0];
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
    end else if (busy_q) begin
      rem_d = ge ? WIN_W'(rem_sh - {1'b0, div_q}) : rem_sh[WIN_W-1:0];
      mag_d = {mag_q[MAG_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign q_signed = neg_q ? (~mag_q + 1'b1) : mag_q;
  assign quot_o   = q_signed[SAMPLE_W-1:0];
  assign done_o   = done_q;

endmodule

### sv/line_box_blur.sv
// Box filter over one line of signed samples, edges replicated. Each output is the
// mean of the 2r+1 samples centered on its position, truncated toward zero, and
// lags the input by r samples; the radius is taken at the first sample of a line.
// The window lives in a chain of 63 sample cells with a running sum beside it; the
// mean comes from a shared restoring divider that yields one quotient bit per cycle.
// A sample that produces an output waits for the divider and for the output register
// to be free, and no new sample is taken meanwhile; a sample that produces none leaves
// the block ready for the next one. The last sample of a line, flagged or at the
// line-length limit, drains the tail: up to r+1 outputs, during which no new sample
// is taken.
module line_box_blur import lbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbb_cfg_if.sink    cfg_i,
  lbb_in_if.sink     in_i,
  lbb_out_if.source  res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_PUT  = 4'b0100,
    ST_TAIL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [RADIUS_W-1:0]        radius_q, radius_d;
  logic [RADIUS_W-1:0]        line_r_q, line_r_d;
  logic [POS_W-1:0]           pos_q, pos_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] hold_q, hold_d;
  logic                       tail_q, tail_d;
  logic [RADIUS_W-1:0]        k_q, k_d;
  logic [RADIUS_W-1:0]        skip_q, skip_d;
  logic                       out_v_q, out_v_d;
  logic signed [SAMPLE_W-1:0] out_avg_q, out_avg_d;
  logic                       out_end_q, out_end_d;

  logic                       accept;
  logic                       first;
  logic                       last;
  logic                       reach;
  logic [RADIUS_W-1:0]        r_l;
  logic [WIN_W-1:0]           w_fill;
  logic [WIN_W-1:0]           w_div;
  logic [CELL_IDX_W-1:0]      entry;
  logic signed [SAMPLE_W-1:0] bus;
  logic signed [SUM_W-1:0]    bus_ext, old_ext, w_ext;
  logic                       load_out;
  logic                       go_div;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quot;
  cell_ctrl_t                 cell_ctrl;

  logic signed [SAMPLE_W-1:0] cell_val [NUM_CELLS];
  logic signed [SAMPLE_W-1:0] cell_prev [NUM_CELLS];

  // configuration
  assign cfg_i.ready = 1'b1;

  always_comb begin
    radius_d = radius_q;
    if (cfg_i.valid) begin
      radius_d = (cfg_i.radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                        : cfg_i.radius;
    end
  end

  // sample chain
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign first      = (pos_q == '0);
  assign r_l        = first ? radius_q : line_r_q;
  assign last       = in_i.last_in_line || (pos_q == POS_W'(MAX_LINE - 1));
  assign reach      = CMP_W'(pos_q) >= CMP_W'(r_l);
  assign line_r_d   = accept ? r_l : line_r_q;
  assign w_fill     = WIN_W'({r_l, 1'b1});
  assign w_div      = WIN_W'({line_r_d, 1'b1});
  assign entry      = CELL_IDX_W'(NUM_CELLS - 1) - CELL_IDX_W'({line_r_q, 1'b0});
  assign bus        = (state_q == ST_TAIL) ? hold_q : in_i.sample;

  assign cell_ctrl.fill  = accept && first;
  assign cell_ctrl.shift = (accept && !first) || (state_q == ST_TAIL);

  assign bus_ext = {{(SUM_W - SAMPLE_W){bus[SAMPLE_W-1]}}, bus};
  assign old_ext = {{(SUM_W - SAMPLE_W){cell_val[NUM_CELLS-1][SAMPLE_W-1]}},
                    cell_val[NUM_CELLS-1]};
  assign w_ext   = {{(SUM_W - WIN_W){1'b0}}, w_fill};

  assign cell_prev[0] = bus;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_prev[i] = cell_val[i-1];
    end
    lbb_cell u_cell (
      .clk_i,
      .ctrl_i  (cell_ctrl),
      .entry_i (entry == CELL_IDX_W'(i)),
      .bus_i   (bus),
      .prev_i  (cell_prev[i]),
      .val_o   (cell_val[i])
    );
  end

  // sequencer
  assign load_out = (state_q == ST_PUT) && (!out_v_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    tail_d  = tail_q;
    k_d     = k_q;
    skip_d  = skip_q;
    go_div  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hold_d = in_i.sample;
          // first sample of a line primes the whole window with itself
          if (first) begin
            sum_d = bus_ext * w_ext;
          end else begin
            sum_d = sum_q + bus_ext - old_ext;
          end
          if (!last) begin
            pos_d = pos_q + 1'b1;
            if (reach) begin
              go_div  = 1'b1;
              state_d = ST_DIV;
            end
          end else begin
            pos_d  = '0;
            tail_d = 1'b1;
            k_d    = '0;
            skip_d = reach ? '0 : (r_l - RADIUS_W'(pos_q));
            if (reach) begin
              go_div  = 1'b1;
              state_d = ST_DIV;
            end else begin
              state_d = ST_TAIL;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (load_out) begin
          if (tail_q && (k_q != line_r_q)) begin
            state_d = ST_TAIL;
          end else begin
            tail_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        // replicate the last sample past the end of the line
        sum_d = sum_q + bus_ext - old_ext;
        k_d   = k_q + 1'b1;
        if ((k_q + 1'b1) >= skip_q) begin
          go_div  = 1'b1;
          state_d = ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  lbb_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (go_div),
    .dividend_i (sum_d),
    .divisor_i  (w_div),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // output word register
  always_comb begin
    out_v_d   = out_v_q;
    out_avg_d = out_avg_q;
    out_end_d = out_end_q;
    if (load_out) begin
      out_v_d   = 1'b1;
      out_avg_d = div_quot;
      out_end_d = tail_q && (k_q == line_r_q);
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.average  = out_avg_q;
  assign res_o.line_end = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      radius_q <= RADIUS_W'(1);
      line_r_q <= RADIUS_W'(1);
      pos_q    <= '0;
      sum_q    <= '0;
      tail_q   <= 1'b0;
      k_q      <= '0;
      skip_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      radius_q <= radius_d;
      line_r_q <= line_r_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      tail_q   <= tail_d;
      k_q      <= k_d;
      skip_q   <= skip_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q    <= hold_d;
    out_avg_q <= out_avg_d;
    out_end_q <= out_end_d;
  end

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TAIL |-> tail_q && (k_q < line_r_q))
    else $error("tail step beyond the window radius");

  a_ready_not_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !tail_q)
    else $error("new sample taken while the line tail is draining");

  a_hold_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT && out_v_q && !res_o.ready) |=> state_q == ST_PUT)
    else $error("result left before the output register was free");

endmodule

### bench/line_box_blur_test.sv
module line_box_blur_test;
  import lbb_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TAP_DEPTH      = 64;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 600;
  localparam int PHASE_WORDS    = 27;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int REPORT_CAP     = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_in_line;
  } sample_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                line_end;
  } mean_word_t;

  logic clk_i;
  logic rst_ni;

  lbb_cfg_if cfg_bus ();
  lbb_in_if  in_bus ();
  lbb_out_if res_bus ();

  line_box_blur u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .res_o  (res_bus)
  );

  // words waiting to be offered, and means waiting to come out
  sample_word_t sample_queue [$];
  mean_word_t   pending_means [$];

  // filter state as the block should hold it
  logic signed [SAMPLE_W-1:0] tap_mem [TAP_DEPTH];
  logic signed [SAMPLE_W-1:0] first_val;
  int                         pos_count;
  int                         cfg_radius;
  int                         line_radius;

  int words_queued;
  int words_accepted;
  int results_seen;
  int lines_done;
  int max_burst;
  int error_count;

  int in_gap_max;
  int out_stall_max;
  int send_gap;
  int recv_stall;
  int hold_seq;
  int hold_seen;
  int hold_left;
  int line_left;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_CAP) $display("MISMATCH: %s", msg);
  endtask

  // mean of the window centered on p; positions past n repeat sample n
  function automatic logic signed [SAMPLE_W-1:0] box_mean(input int p, input int n,
                                                          input int r);
    longint acc;
    int     q;
    acc = 0;
    for (int k = -r; k <= r; k++) begin
      q = p + k;
      if (q < 0) acc += longint'(first_val);
      else if (q > n) acc += longint'(tap_mem[n % TAP_DEPTH]);
      else acc += longint'(tap_mem[q % TAP_DEPTH]);
    end
    return SAMPLE_W'(acc / longint'(2 * r + 1));
  endfunction

  function automatic void predict_means(input sample_word_t w);
    int         n;
    int         p;
    int         burst;
    logic       fin;
    mean_word_t m;
    n = pos_count;
    burst = 0;
    if (n == 0) begin
      line_radius = cfg_radius;
      first_val = w.sample;
    end
    tap_mem[n % TAP_DEPTH] = w.sample;
    // an overlong line is cut at the last position the block can count
    fin = w.last_in_line || (n >= MAX_LINE - 1);
    if (!fin) begin
      if (n >= line_radius) begin
        m.average = box_mean(n - line_radius, n, line_radius);
        m.line_end = 1'b0;
        pending_means.push_back(m);
        burst = 1;
      end
      pos_count = n + 1;
    end else begin
      p = (n > line_radius) ? n - line_radius : 0;
      while (p <= n) begin
        m.average = box_mean(p, n, line_radius);
        m.line_end = (p == n);
        pending_means.push_back(m);
        burst++;
        p++;
      end
      pos_count = 0;
      lines_done++;
    end
    if (burst > max_burst) max_burst = burst;
  endfunction

  // monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin : monitor_proc
    mean_word_t   want;
    sample_word_t got_in;
    in_taken  <= in_bus.valid && in_bus.ready;
    out_taken <= res_bus.valid && res_bus.ready;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (pending_means.size() == 0) begin
          report_mismatch($sformatf("result word %0d with nothing pending: avg %0d end %0b",
                                    results_seen, $signed(res_bus.average),
                                    res_bus.line_end));
        end else begin
          want = pending_means.pop_front();
          if (res_bus.average !== want.average)
            report_mismatch($sformatf("result word %0d: average %0d, wanted %0d",
                                      results_seen, $signed(res_bus.average),
                                      $signed(want.average)));
          if (res_bus.line_end !== want.line_end)
            report_mismatch($sformatf("result word %0d: line_end %0b, wanted %0b",
                                      results_seen, res_bus.line_end, want.line_end));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        got_in.sample = in_bus.sample;
        got_in.last_in_line = in_bus.last_in_line;
        predict_means(got_in);
        words_accepted++;
      end
    end
  end

  // driver: hold the word until taken, then wait out the drawn gap
  always @(negedge clk_i) begin : driver_proc
    sample_word_t nxt;
    if (rst_ni && (!in_bus.valid || in_taken)) begin
      if (send_gap > 0 || sample_queue.size() == 0) begin
        in_bus.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        nxt = sample_queue.pop_front();
        in_bus.sample       <= nxt.sample;
        in_bus.last_in_line <= nxt.last_in_line;
        in_bus.valid        <= 1'b1;
        send_gap = $urandom_range(0, in_gap_max);
      end
    end
  end

  // receiver: random stall before each result, plus a long hold on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else if (out_taken || !res_bus.ready) begin
      if (out_taken) recv_stall = $urandom_range(0, out_stall_max);
      if (recv_stall > 0) begin
        recv_stall--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic fin);
    sample_word_t w;
    w.sample = s;
    w.last_in_line = fin;
    sample_queue.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_accepted != words_queued || pending_means.size() != 0);
    // a word that yields no mean may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_radius(input int r);
    @(negedge clk_i);
    cfg_bus.radius <= RADIUS_W'(r);
    cfg_bus.valid  <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_radius = r;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    v = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return v[SAMPLE_W-1:0];
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // lines run on across calls, so a call may stop mid-line
  task automatic queue_random_words(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (line_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) line_left = $urandom_range(1, 8);
        else if (pick < 8) line_left = $urandom_range(9, 40);
        else line_left = $urandom_range(41, 80);
      end
      line_left--;
      queue_sample(pick_sample(), line_left == 0);
    end
  endtask

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout: %0d of %0d words taken, %0d means pending",
             words_accepted, words_queued, pending_means.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int r;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.last_in_line = 1'b0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.radius = '0;
    for (int i = 0; i < TAP_DEPTH; i++) tap_mem[i] = '0;
    first_val = '0;
    pos_count = 0;
    cfg_radius = 1;
    line_radius = 1;
    words_queued = 0;
    words_accepted = 0;
    results_seen = 0;
    lines_done = 0;
    max_burst = 0;
    error_count = 0;
    in_gap_max = 13;
    out_stall_max = 13;
    send_gap = 0;
    recv_stall = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    line_left = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset radius, full-scale extremes, then a line of one word
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    queue_sample(16'sh8000, 1'b1);
    wait_drained();

    // zero radius passes words through with no lag
    write_radius(0);
    queue_sample(16'sd5, 1'b0);
    queue_sample(-16'sd7, 1'b0);
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    wait_drained();

    // widest window over a line much shorter than it
    write_radius(31);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh7fff, 1'b1);
    wait_drained();

    // negative sum that must round toward zero
    write_radius(1);
    queue_sample(-16'sd2, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd0, 1'b1);
    wait_drained();

    // radius rewritten mid-line: the line keeps the radius it started with
    write_radius(2);
    queue_sample(16'sd100, 1'b0);
    queue_sample(-16'sd100, 1'b0);
    queue_sample(16'sd7, 1'b0);
    wait_drained();
    write_radius(5);
    queue_sample(16'sd9, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0, 5:    r = 31;
        1, 4, 6: r = 0;
        default: r = $urandom_range(0, 31);
      endcase
      write_radius(r);
      in_gap_max    = (ph == 3 || ph == 4 || ph == 8) ? 0 : 13;
      out_stall_max = (ph == 3 || ph == 8) ? 0 : 13;
      // one line wide enough to drain a full tail of 32 means
      if (ph == 0 && line_left == 0) line_left = 40;
      // flood the block while the receiver holds off
      if (ph == 4) hold_seq++;
      queue_random_words(PHASE_WORDS);
      wait_drained();
    end
    if (line_left > 0) queue_random_words(line_left);
    wait_drained();

    if (pending_means.size() != 0)
      report_mismatch($sformatf("%0d means never arrived", pending_means.size()));

    $display("Sent %0d sample words in %0d lines, radius 0 to 31, short and long lines.",
             words_accepted, lines_done);
    $display("Checked %0d mean words, up to %0d from one word, under random and long stalls.",
             results_seen, max_burst);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
